// ----- design/assert_macros.svh -----
// Assertion helper macros shared by the RTL.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk_s, rst_s, cond, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (cond)) else $error(msg);
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk_s, rst_s, cond, msg)
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif
`endif

// ----- design/lpwu_pkg.sv -----
// Shared types, codes, tables and helper functions of the pixel word unpacker.
// No dependencies.
`timescale 1ns / 1ps

package lpwu_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int DATA_W = 40;

    // pixel format codes
    localparam logic [3:0] BPP_1       = 4'd0;
    localparam logic [3:0] BPP_1_ALT   = 4'd8;
    localparam logic [3:0] BPP_2       = 4'd1;
    localparam logic [3:0] BPP_2_ALT   = 4'd9;
    localparam logic [3:0] BPP_4       = 4'd2;
    localparam logic [3:0] BPP_4_ALT   = 4'd10;
    localparam logic [3:0] BPP_STN8    = 4'd3;
    localparam logic [3:0] BPP_STN12P  = 4'd4;
    localparam logic [3:0] BPP_STN12U  = 4'd5;
    localparam logic [3:0] BPP_STN16   = 4'd6;
    localparam logic [3:0] BPP_TFT8    = 4'd11;
    localparam logic [3:0] BPP_TFT16   = 4'd12;
    localparam logic [3:0] BPP_TFT24   = 4'd13;

    // swap codes
    localparam logic [1:0] SWAP_NONE       = 2'd0;
    localparam logic [1:0] SWAP_HALVES     = 2'd1;
    localparam logic [1:0] SWAP_BYTES      = 2'd2;
    localparam logic [1:0] SWAP_HALF_BYTES = 2'd3;

    // register indexes
    localparam logic [2:0] REG_BPP   = 3'd0;
    localparam logic [2:0] REG_SWAP  = 3'd1;
    localparam logic [2:0] REG_RED   = 3'd2;
    localparam logic [2:0] REG_GREEN = 3'd3;
    localparam logic [2:0] REG_BLUE  = 3'd4;

    localparam logic [1:0] PHASE_RED   = 2'd0;
    localparam logic [1:0] PHASE_GREEN = 2'd1;
    localparam logic [1:0] PHASE_BLUE  = 2'd2;

    typedef struct packed {
        logic [31:0] red;
        logic [31:0] green;
        logic [15:0] blue;
    } lut_t;

    localparam logic [4:0] GAM5 [16] = '{5'h00, 5'h02, 5'h04, 5'h06, 5'h08, 5'h0a, 5'h0c,
        5'h0e, 5'h11, 5'h13, 5'h15, 5'h17, 5'h19, 5'h1b, 5'h1d, 5'h1f};
    localparam logic [5:0] GAM6 [16] = '{6'h00, 6'h04, 6'h08, 6'h0d, 6'h11, 6'h15, 6'h19,
        6'h1d, 6'h22, 6'h26, 6'h2a, 6'h2e, 6'h32, 6'h37, 6'h3b, 6'h3f};
    localparam logic [15:0] GRAY2 [4] = '{16'hffff, 16'hA554, 16'h52AA, 16'h0000};
    localparam logic [15:0] GRAY4 [16] = '{16'hffff, 16'hef7d, 16'hdefb, 16'hce59,
        16'hbdd7, 16'had55, 16'h9cd3, 16'h8c51, 16'h73ae, 16'h632c, 16'h52aa, 16'h4228,
        16'h31a6, 16'h2104, 16'h1082, 16'h0000};

    function automatic logic [31:0] swap_word(input logic [31:0] v, input logic [1:0] sm);
        logic [31:0] r;
        case (sm)
            SWAP_HALVES:     r = {v[15:0], v[31:16]};
            SWAP_BYTES:      r = {v[7:0], v[15:8], v[23:16], v[31:24]};
            SWAP_HALF_BYTES: r = {v[23:16], v[31:24], v[7:0], v[15:8]};
            default:         r = v;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] pack_gamma(input logic [3:0] r, input logic [3:0] g,
                                               input logic [3:0] b);
        return {GAM5[r], GAM6[g], GAM5[b]};
    endfunction

    // pixels produced by one word; packed 12bpp depends on the nibble phase
    function automatic logic [5:0] pixel_count(input logic [3:0] bpp, input logic [1:0] ph);
        logic [5:0] n;
        case (bpp)
            BPP_1, BPP_1_ALT:                   n = 6'd32;
            BPP_2, BPP_2_ALT:                   n = 6'd16;
            BPP_4, BPP_4_ALT:                   n = 6'd8;
            BPP_STN8, BPP_TFT8:                 n = 6'd4;
            BPP_STN12P:                         n = (ph == PHASE_RED) ? 6'd2 : 6'd3;
            BPP_STN12U, BPP_STN16, BPP_TFT16:   n = 6'd2;
            BPP_TFT24:                          n = 6'd1;
            default:                            n = 6'd0;
        endcase
        return n;
    endfunction

endpackage

// ----- design/lpwu_decode.sv -----
// Pixel decoder: turns the top bits of the working word into one RGB565 pixel.
// Depends on lpwu_pkg (codes, gamma and gray tables).
`timescale 1ns / 1ps

module lpwu_decode (
    input  logic [3:0]                  bpp,
    input  logic [lpwu_pkg::DATA_W-1:0] data,
    input  lpwu_pkg::lut_t              lut,
    output logic [15:0]                 pixel
);
    import lpwu_pkg::*;

    logic [7:0]  p8;
    logic [15:0] h16;
    logic [3:0]  r_lvl;
    logic [3:0]  g_lvl;
    logic [3:0]  b_lvl;

    assign p8    = data[39:32];
    assign h16   = data[39:24];
    assign r_lvl = lut.red[{p8[7:5], 2'b00} +: 4];
    assign g_lvl = lut.green[{p8[4:2], 2'b00} +: 4];
    assign b_lvl = lut.blue[{p8[1:0], 2'b00} +: 4];

    always_comb
    begin
        case (bpp)
            BPP_1, BPP_1_ALT: pixel = data[39] ? 16'h0000 : 16'hffff;
            BPP_2, BPP_2_ALT: pixel = GRAY2[data[39:38]];
            BPP_4, BPP_4_ALT: pixel = GRAY4[data[39:36]];
            BPP_STN8:         pixel = pack_gamma(r_lvl, g_lvl, b_lvl);
            BPP_STN12P:       pixel = pack_gamma(data[39:36], data[35:32], data[31:28]);
            BPP_STN12U:       pixel = pack_gamma(h16[11:8], h16[7:4], h16[3:0]);
            BPP_STN16:        pixel = pack_gamma(h16[15:12], h16[10:7], h16[4:1]);
            BPP_TFT16:        pixel = h16;
            // word sits at [39:8]: red 23..19, green 15..10, blue 7..3
            BPP_TFT24:        pixel = {data[31:27], data[23:18], data[15:11]};
            default:          pixel = 16'h0000;
        endcase
    end

endmodule

// ----- design/lcd_pixel_word_unpacker.sv -----
// LCD frame-buffer word unpacker, top level: APB registers, input stage,
// pixel serializer, palette memory and output register.
// Depends on lpwu_pkg, lpwu_decode and assert_macros.svh.
//
// Usage:
//  - Input channel (in_valid/in_ready): one beat is either a frame-buffer word
//    (mode 0) or a palette write (mode 1, pal_value into entry pal_index).
//  - Output channel (out_valid/out_ready): one RGB565 pixel per beat, most
//    significant pixel of the word first; last marks a word's final pixel.
//  - An input beat passes the input register and the serializer register;
//    pixels leave through the output register. Throughput: one pixel per
//    cycle while the receiver accepts. The serializer's pixel counter holds a
//    word until all its pixels are out: 32 (1bpp), 16, 8, 4, 2 or 3, 2, 1.
//    Palette writes and unsupported formats pass through and give no pixel.
//  - TFT 8bpp pixels read the 256-entry palette one entry per output beat;
//    the memory read register doubles as the output pixel register.
//  - Registers are to be written over APB only while idle; not enforced.
//  - Reset clears registers, pipeline valids and the 12bpp nibble phase; the
//    palette is not cleared and must be written before it is used.
//  - When the receiver stalls, the output holds; one more item waits in the
//    input register and then in_ready drops.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lcd_pixel_word_unpacker #(
    parameter int PALETTE_DEPTH = lpwu_pkg::PALETTE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [31:0] fb_word,
    input  logic [7:0]  pal_index,
    input  logic [15:0] pal_value,
    // output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] pixel,
    output logic        last
);
    import lpwu_pkg::*;

    localparam int PAL_AW = $clog2(PALETTE_DEPTH);

    // configuration
    logic [3:0]  bpp_mode_reg;
    logic [1:0]  swap_mode_reg;
    lut_t        lut_reg;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    // input stage
    logic        a_valid_reg;
    logic        a_mode_reg;
    logic [31:0] a_word_reg;
    logic [7:0]  a_pal_index_reg;
    logic [15:0] a_pal_value_reg;
    logic        in_beat;
    logic        a_take;
    logic [5:0]  a_count;
    logic        load_b;
    logic        pal_we;

    // 12bpp packed carry state
    logic [1:0]  phase_reg;
    logic [3:0]  held_red_reg;
    logic [3:0]  held_green_reg;
    logic        packed_step;

    // serializer
    logic              b_valid_reg;
    logic [3:0]        b_bpp_reg;
    logic [5:0]        b_left_reg;
    logic [DATA_W-1:0] b_data_reg;
    logic [DATA_W-1:0] b_data_next;
    logic [DATA_W-1:0] b_shifted;
    logic              b_done;
    logic              b_free;
    logic [15:0]       dec_pixel;

    // output register
    logic        out_valid_reg;
    logic        out_last_reg;
    logic        out_pal_reg;
    logic [15:0] out_pix_reg;
    logic [15:0] pal_rd_reg;
    logic        out_load;

    logic [15:0] palette_mem [PALETTE_DEPTH];

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_mode_reg  <= 4'd0;
            swap_mode_reg <= 2'd0;
            lut_reg       <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_BPP:   bpp_mode_reg  <= pwdata[3:0];
                REG_SWAP:  swap_mode_reg <= pwdata[1:0];
                REG_RED:   lut_reg.red   <= pwdata;
                REG_GREEN: lut_reg.green <= pwdata;
                REG_BLUE:  lut_reg.blue  <= pwdata[15:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_BPP:   prdata = {28'd0, bpp_mode_reg};
            REG_SWAP:  prdata = {30'd0, swap_mode_reg};
            REG_RED:   prdata = lut_reg.red;
            REG_GREEN: prdata = lut_reg.green;
            REG_BLUE:  prdata = {16'd0, lut_reg.blue};
            default:   prdata = 32'd0;
        endcase
    end

    // ---------------- handshake ----------------
    assign out_load = b_valid_reg && (!out_valid_reg || out_ready);
    assign b_done   = out_load && (b_left_reg == 6'd1);
    assign b_free   = !b_valid_reg || b_done;
    assign a_take   = a_valid_reg && b_free;
    assign in_ready = !a_valid_reg || a_take;
    assign in_beat  = in_valid && in_ready;

    assign a_count     = pixel_count(bpp_mode_reg, phase_reg);
    assign load_b      = a_take && !a_mode_reg && (a_count != 6'd0);
    assign pal_we      = a_take && a_mode_reg;
    assign packed_step = a_take && !a_mode_reg && (bpp_mode_reg == BPP_STN12P);

    // ---------------- input stage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (in_beat)
            a_valid_reg <= 1'b1;
        else if (a_take)
            a_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            a_mode_reg      <= mode;
            a_word_reg      <= swap_word(fb_word, swap_mode_reg);
            a_pal_index_reg <= pal_index;
            a_pal_value_reg <= pal_value;
        end
    end

    // ---------------- 12bpp packed nibble carry ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PHASE_RED;
            held_red_reg   <= 4'd0;
            held_green_reg <= 4'd0;
        end
        else if (packed_step)
        begin
            // eight nibbles advance the red/green/blue cycle by two
            case (phase_reg)
                PHASE_RED:
                begin
                    phase_reg      <= PHASE_BLUE;
                    held_red_reg   <= a_word_reg[7:4];
                    held_green_reg <= a_word_reg[3:0];
                end
                PHASE_GREEN:
                begin
                    phase_reg      <= PHASE_RED;
                    held_red_reg   <= a_word_reg[11:8];
                    held_green_reg <= a_word_reg[7:4];
                end
                default:
                begin
                    phase_reg      <= PHASE_GREEN;
                    held_red_reg   <= a_word_reg[3:0];
                    held_green_reg <= a_word_reg[11:8];
                end
            endcase
        end
    end

    // ---------------- serializer ----------------
    // word is left-aligned; packed 12bpp prepends the held nibbles
    always_comb
    begin
        if (bpp_mode_reg == BPP_STN12P && phase_reg == PHASE_GREEN)
            b_data_next = {held_red_reg, a_word_reg, 4'h0};
        else if (bpp_mode_reg == BPP_STN12P && phase_reg == PHASE_BLUE)
            b_data_next = {held_red_reg, held_green_reg, a_word_reg};
        else
            b_data_next = {a_word_reg, 8'h00};
    end

    always_comb
    begin
        case (b_bpp_reg)
            BPP_1, BPP_1_ALT:                 b_shifted = b_data_reg << 1;
            BPP_2, BPP_2_ALT:                 b_shifted = b_data_reg << 2;
            BPP_4, BPP_4_ALT:                 b_shifted = b_data_reg << 4;
            BPP_STN8, BPP_TFT8:               b_shifted = b_data_reg << 8;
            BPP_STN12P:                       b_shifted = b_data_reg << 12;
            BPP_STN12U, BPP_STN16, BPP_TFT16: b_shifted = b_data_reg << 16;
            default:                          b_shifted = b_data_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            b_left_reg  <= 6'd0;
            b_bpp_reg   <= 4'd0;
        end
        else if (load_b)
        begin
            b_valid_reg <= 1'b1;
            b_left_reg  <= a_count;
            b_bpp_reg   <= bpp_mode_reg;
        end
        else if (out_load)
        begin
            b_valid_reg <= !b_done;
            b_left_reg  <= b_left_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_b)
            b_data_reg <= b_data_next;
        else if (out_load)
            b_data_reg <= b_shifted;
    end

    lpwu_decode u_decode (
        .bpp   (b_bpp_reg),
        .data  (b_data_reg),
        .lut   (lut_reg),
        .pixel (dec_pixel)
    );

    // ---------------- palette memory ----------------
    always_ff @(posedge clk)
    begin
        if (pal_we)
            palette_mem[a_pal_index_reg[PAL_AW-1:0]] <= a_pal_value_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            pal_rd_reg <= palette_mem[b_data_reg[DATA_W-1 -: PAL_AW]];
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_pix_reg  <= dec_pixel;
            out_last_reg <= (b_left_reg == 6'd1);
            out_pal_reg  <= (b_bpp_reg == BPP_TFT8);
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel     = out_pal_reg ? pal_rd_reg : out_pix_reg;
    assign last      = out_last_reg;

    // ---------------- assertions ----------------
    `ASSERT_ALWAYS(a_left_nonzero, clk, rst_n, !b_valid_reg || (b_left_reg != 6'd0), "serializer busy with no pixels left")
    `ASSERT_ALWAYS(a_phase_legal, clk, rst_n, phase_reg != 2'd3, "nibble phase out of range")
    `ASSERT_NEXT(a_load_busy, clk, rst_n, load_b, b_valid_reg && (b_left_reg != 6'd0), "word loaded but serializer idle")
    `ASSERT_NEXT(a_pal_no_pixel, clk, rst_n, pal_we && !b_valid_reg, !b_valid_reg, "palette write started a pixel run")

endmodule

// ----- tb/tb_lcd_pixel_word_unpacker.sv -----
// Self-checking testbench for lcd_pixel_word_unpacker: APB setup, a driver fed
// from a beat queue, a pixel predictor and a monitor that checks every pixel beat.
// Depends on lpwu_pkg and the lcd_pixel_word_unpacker RTL.
`timescale 1ns / 1ps

module tb_lcd_pixel_word_unpacker;
    import lpwu_pkg::*;

    // formats the block does not decode
    localparam logic [3:0] BPP_RSVD7  = 4'd7;
    localparam logic [3:0] BPP_RSVD14 = 4'd14;
    localparam logic [3:0] BPP_RSVD15 = 4'd15;

    localparam int NUM_PHASES     = 18;
    localparam int BEATS_PER_PHASE = 12;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_PRINTS     = 100;

    typedef struct packed {
        logic        mode;
        logic [31:0] word;
        logic [7:0]  idx;
        logic [15:0] val;
    } fb_beat_t;

    typedef struct packed {
        logic [15:0] pixel;
        logic        last;
    } pix_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        mode = 1'b0;
    logic [31:0] fb_word = '0;
    logic [7:0]  pal_index = '0;
    logic [15:0] pal_value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] pixel;
    logic        last;

    lcd_pixel_word_unpacker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .fb_word   (fb_word),
        .pal_index (pal_index),
        .pal_value (pal_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel     (pixel),
        .last      (last)
    );

    always #2 clk = ~clk;

    fb_beat_t    beat_q [$];
    pix_t        pixel_q [$];
    logic [7:0]  pal_written [$];
    fb_beat_t    next_beat;
    pix_t        want_px;
    logic        in_beat = 1'b0;
    int          send_idle = 33;
    int          recv_idle = 75;
    int          err_count = 0;

    // predictor state
    logic [3:0]  cfg_bpp = '0;
    logic [1:0]  cfg_swap = '0;
    logic [31:0] cfg_red = '0;
    logic [31:0] cfg_green = '0;
    logic [15:0] cfg_blue = '0;
    logic [15:0] pal_mem [256];
    logic [1:0]  nib_phase = PHASE_RED;
    logic [3:0]  held_r = '0;
    logic [3:0]  held_g = '0;

    task automatic flag_error(input string msg);
        if (err_count < MAX_PRINTS)
            $display("%0t mismatch: %s", $time, msg);
        err_count++;
    endtask

    // 4-bit level to 5/6-bit gamma, rounded i*31/15 and i*63/15
    function automatic logic [4:0] gamma5(input logic [3:0] n);
        return 5'((62 * int'(n) + 15) / 30);
    endfunction

    function automatic logic [5:0] gamma6(input logic [3:0] n);
        return 6'((126 * int'(n) + 15) / 30);
    endfunction

    function automatic logic [15:0] rgb_levels(input logic [3:0] r, input logic [3:0] g,
                                               input logic [3:0] b);
        return {gamma5(r), gamma6(g), gamma5(b)};
    endfunction

    function automatic logic [15:0] shade2(input logic [1:0] c);
        case (c)
            2'd0:    return 16'hffff;
            2'd1:    return 16'hA554;
            2'd2:    return 16'h52AA;
            default: return 16'h0000;
        endcase
    endfunction

    // expected pixels of one accepted input beat
    task automatic unpack_beat(input logic m, input logic [31:0] w, input logic [7:0] idx,
                               input logic [15:0] val);
        logic [31:0] v;
        logic [15:0] px [$];
        logic [7:0]  b;
        logic [3:0]  nib;
        logic [15:0] h;
        if (m)
        begin
            pal_mem[idx] = val;
            return;
        end
        case (cfg_swap)
            SWAP_HALVES:     v = (w >> 16) | (w << 16);
            SWAP_BYTES:      v = {w[7:0], w[15:8], w[23:16], w[31:24]};
            SWAP_HALF_BYTES: v = ((w & 32'hff00ff00) >> 8) | ((w << 8) & 32'hff00ff00);
            default:         v = w;
        endcase
        case (cfg_bpp)
            BPP_1, BPP_1_ALT:
                for (int i = 31; i >= 0; i--)
                    px.push_back(v[i] ? 16'h0000 : 16'hffff);
            BPP_2, BPP_2_ALT:
                for (int i = 15; i >= 0; i--)
                    px.push_back(shade2(v[2*i +: 2]));
            BPP_4, BPP_4_ALT:
                // 16-level gray ramp is the gamma of the inverted code on all channels
                for (int i = 7; i >= 0; i--)
                    px.push_back(rgb_levels(~v[4*i +: 4], ~v[4*i +: 4], ~v[4*i +: 4]));
            BPP_STN8:
                for (int i = 3; i >= 0; i--)
                begin
                    b = v[8*i +: 8];
                    px.push_back(rgb_levels(cfg_red[{b[7:5], 2'b00} +: 4],
                                            cfg_green[{b[4:2], 2'b00} +: 4],
                                            cfg_blue[{b[1:0], 2'b00} +: 4]));
                end
            BPP_STN12P:
                for (int i = 7; i >= 0; i--)
                begin
                    nib = v[4*i +: 4];
                    case (nib_phase)
                        PHASE_RED:
                        begin
                            held_r = nib;
                            nib_phase = PHASE_GREEN;
                        end
                        PHASE_GREEN:
                        begin
                            held_g = nib;
                            nib_phase = PHASE_BLUE;
                        end
                        default:
                        begin
                            px.push_back(rgb_levels(held_r, held_g, nib));
                            nib_phase = PHASE_RED;
                        end
                    endcase
                end
            BPP_STN12U:
                for (int i = 1; i >= 0; i--)
                begin
                    h = v[16*i +: 16];
                    px.push_back(rgb_levels(h[11:8], h[7:4], h[3:0]));
                end
            BPP_STN16:
                for (int i = 1; i >= 0; i--)
                begin
                    h = v[16*i +: 16];
                    px.push_back(rgb_levels(h[15:12], h[10:7], h[4:1]));
                end
            BPP_TFT8:
                for (int i = 3; i >= 0; i--)
                    px.push_back(pal_mem[v[8*i +: 8]]);
            BPP_TFT16:
            begin
                px.push_back(v[31:16]);
                px.push_back(v[15:0]);
            end
            BPP_TFT24:
                px.push_back({v[23:19], v[15:10], v[7:3]});
            default:
                ;
        endcase
        foreach (px[k])
            pixel_q.push_back('{pixel: px[k], last: (k == px.size() - 1)});
    endtask

    // sampling side: input acceptance and pixel checks
    always @(posedge clk)
    begin
        in_beat = rst_n && in_valid && in_ready;
        if (in_beat)
            unpack_beat(mode, fb_word, pal_index, pal_value);
        if (rst_n && out_valid && out_ready)
        begin
            if (pixel_q.size() == 0)
                flag_error($sformatf("pixel %h last %b with none expected", pixel, last));
            else
            begin
                want_px = pixel_q.pop_front();
                if (pixel !== want_px.pixel)
                    flag_error($sformatf("pixel %h, expected %h", pixel, want_px.pixel));
                if (last !== want_px.last)
                    flag_error($sformatf("last %b, expected %b on pixel %h",
                                         last, want_px.last, want_px.pixel));
            end
        end
    end

    // driver: a new beat is offered only once the held one has gone
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_beat)
        begin
            if (beat_q.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                next_beat = beat_q.pop_front();
                in_valid  <= 1'b1;
                mode      <= next_beat.mode;
                fb_word   <= next_beat.word;
                pal_index <= next_beat.idx;
                pal_value <= next_beat.val;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle);

    task automatic push_word(input logic [31:0] w);
        beat_q.push_back('{mode: 1'b0, word: w, idx: 8'($urandom), val: 16'($urandom)});
    endtask

    task automatic push_pal(input logic [7:0] idx, input logic [15:0] val);
        beat_q.push_back('{mode: 1'b1, word: $urandom, idx: idx, val: val});
        pal_written.push_back(idx);
    endtask

    // wait until every queued beat is in and every pixel is out, then let it settle
    task automatic drain();
        while (beat_q.size() != 0 || in_valid || pixel_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apb_write(input logic [2:0] reg_idx, input logic [31:0] data);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {reg_idx, 2'b00};
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apply_config(input logic [3:0] fmt, input logic [1:0] swp,
                                input logic [31:0] r, input logic [31:0] g,
                                input logic [15:0] b);
        drain();
        apb_write(REG_BPP, {28'd0, fmt});
        apb_write(REG_SWAP, {30'd0, swp});
        apb_write(REG_RED, r);
        apb_write(REG_GREEN, g);
        apb_write(REG_BLUE, {16'd0, b});
        cfg_bpp   = fmt;
        cfg_swap  = swp;
        cfg_red   = r;
        cfg_green = g;
        cfg_blue  = b;
    endtask

    function automatic logic [3:0] phase_format(input int p);
        case (p)
            0:       return BPP_1_ALT;
            1:       return BPP_2;
            2:       return BPP_4_ALT;
            3:       return BPP_STN8;
            4:       return BPP_STN12P;
            5:       return BPP_STN12U;
            6:       return BPP_STN12P;
            7:       return BPP_RSVD14;
            8:       return BPP_STN16;
            9:       return BPP_TFT8;
            10:      return BPP_TFT16;
            11:      return BPP_TFT24;
            12:      return BPP_STN8;
            13:      return BPP_1;
            14:      return BPP_RSVD15;
            15:      return BPP_2_ALT;
            16:      return BPP_4;
            default: return BPP_TFT8;
        endcase
    endfunction

    initial
    begin
        #2_000_000;
        $display("[lcd_pixel_word_unpacker] ERROR");
        $finish;
    end

    initial
    begin
        logic [3:0]  fmt;
        logic [31:0] w;
        int          waited;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes and each format
        apply_config(BPP_1, SWAP_NONE, 32'h0, 32'h0, 16'h0);
        push_word(32'h0000_0000);
        push_word(32'hffff_ffff);
        push_word(32'h8000_0001);
        apply_config(BPP_2_ALT, SWAP_HALVES, 32'h0, 32'h0, 16'h0);
        push_word(32'h1b1b_e4e4);
        apply_config(BPP_4, SWAP_BYTES, 32'h0, 32'h0, 16'h0);
        push_word(32'h0123_4567);
        push_word(32'h89ab_cdef);
        apply_config(BPP_STN8, SWAP_HALF_BYTES, 32'h7654_3210, 32'hfedc_ba98, 16'hf0a5);
        push_word(32'h00ff_55aa);
        push_word(32'he31c_6d92);
        // packed 12bpp: three words walk the nibble phase through every position
        apply_config(BPP_STN12P, SWAP_NONE, 32'h0, 32'h0, 16'h0);
        push_word(32'h0123_4567);
        push_word(32'h89ab_cdef);
        push_word(32'hfff0_00ff);
        apply_config(BPP_STN12U, SWAP_NONE, 32'hffff_ffff, 32'hffff_ffff, 16'hffff);
        push_word(32'h0fff_0a5c);
        apply_config(BPP_STN16, SWAP_HALVES, 32'hffff_ffff, 32'hffff_ffff, 16'hffff);
        push_word(32'hffff_0001);
        push_pal(8'h00, 16'h0000);
        push_pal(8'hff, 16'hffff);
        push_pal(8'h5a, 16'ha5c3);
        apply_config(BPP_TFT8, SWAP_NONE, 32'h0, 32'h0, 16'h0);
        push_word(32'h00ff_5a00);
        apply_config(BPP_TFT16, SWAP_BYTES, 32'h0, 32'h0, 16'h0);
        push_word(32'hffff_0000);
        apply_config(BPP_TFT24, SWAP_NONE, 32'h0, 32'h0, 16'h0);
        push_word(32'h00ff_ffff);
        push_word(32'hff00_0000);
        apply_config(BPP_RSVD7, SWAP_HALF_BYTES, 32'h0, 32'h0, 16'h0);
        push_word(32'hdead_beef);

        // random phases, one format each
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            fmt = phase_format(p);
            if (p == 3)
                apply_config(fmt, 2'(p), 32'hffff_ffff, 32'hffff_ffff, 16'hffff);
            else
                apply_config(fmt, 2'(p), $urandom, $urandom, 16'($urandom));
            if (p < NUM_PHASES / 3)
            begin
                send_idle = 33;
                recv_idle = 75;
            end
            else if (p < 2 * NUM_PHASES / 3)
            begin
                send_idle = 75;
                recv_idle = 33;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            for (int i = 0; i < BEATS_PER_PHASE; i++)
            begin
                // hold the sender off until the pipe is empty once
                if (p == 4 && i == BEATS_PER_PHASE / 2)
                    drain();
                if ($urandom_range(99) < ((fmt == BPP_TFT8) ? 25 : 8))
                    push_pal(8'($urandom), 16'($urandom));
                else if (fmt == BPP_TFT8)
                begin
                    // palette words only point at entries already written
                    w = '0;
                    for (int k = 0; k < 4; k++)
                        w = {w[23:0], pal_written[$urandom_range(pal_written.size() - 1)]};
                    push_word(w);
                end
                else
                    push_word($urandom);
            end
        end

        waited = 0;
        while ((beat_q.size() != 0 || in_valid || pixel_q.size() != 0) && waited < 100000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (pixel_q.size() != 0)
            flag_error($sformatf("%0d expected pixels never arrived", pixel_q.size()));
        if (err_count == 0)
            $display("[lcd_pixel_word_unpacker] OK");
        else
            $display("[lcd_pixel_word_unpacker] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/lpwu_pkg.sv
design/lpwu_decode.sv
design/lcd_pixel_word_unpacker.sv
tb/tb_lcd_pixel_word_unpacker.sv
